@@ rtl/wrhp_pkg.sv @@
package wrhp_pkg;

  localparam logic [31:0] ID_FMT  = 32'h20746d66;
  localparam logic [31:0] ID_LIST = 32'h5453494c;
  localparam logic [31:0] ID_INFO = 32'h4F464E49;
  localparam logic [31:0] ID_INAM = 32'h4D414E49;
  localparam logic [31:0] ID_IART = 32'h54524149;
  localparam logic [31:0] ID_DATA = 32'h61746164;

  localparam logic [32:0] HEADER_SKIP = 33'd12;
  localparam logic [32:0] FMT_BYTES   = 33'd16;
  localparam logic [32:0] SAT33       = 33'h1FFFFFFFF;

  localparam logic [1:0] KIND_TITLE  = 2'd0;
  localparam logic [1:0] KIND_ARTIST = 2'd1;
  localparam logic [1:0] KIND_SUM    = 2'd2;

  localparam int QW = 32;

  typedef struct packed {
    logic          start;
    logic [QW-1:0] dividend;
    logic [QW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [QW-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/wav_riff_header_parser_unit.sv @@
// Channel | Direction | Contents
// in_*    | input     | one file byte per request, tlast marks the final byte
// out_*   | output    | title/artist text bytes and the end-of-file summary
//
// A byte that produces no request and starts no division leaves in_tready high, so the next
// byte can follow at once. A text byte keeps in_tready low until its request is taken; a final
// byte also waits for its summary request to be taken.
// A data chunk header with a nonzero frame size keeps in_tready low while the divider runs
// and while its quotient is collected, so the next byte waits for the division to finish.
// rst_n is synchronous and active low; after a summary the parser returns to its reset state.
module wav_riff_header_parser_unit #(
  parameter int MAX_TEXT = 127
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] byte_value
  input  logic         in_tlast,   // end_of_file
  output logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] text_byte, [14:8] text_index, [46:15] fmt_rate, [62:47] channels,
  // [78:63] sample_bits, [110:79] data_offset, [142:111] frame_count, [143] 0
  output logic [143:0] out_tdata,
  output logic [1:0]   out_tuser,  // kind
  output logic         out_tlast   // text_last
);

  // Parse phases.
  localparam logic [2:0] PH_SKIP  = 3'd0;
  localparam logic [2:0] PH_CHDR  = 3'd1;
  localparam logic [2:0] PH_FMT   = 3'd2;
  localparam logic [2:0] PH_LTYPE = 3'd3;
  localparam logic [2:0] PH_SHDR  = 3'd4;
  localparam logic [2:0] PH_TEXT  = 3'd5;
  localparam logic [2:0] PH_SSKIP = 3'd6;

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] bpos_r, bpos_nxt;
  logic [31:0] fshift_r, fshift_nxt;
  logic [2:0]  fcnt_r, fcnt_nxt;
  logic [31:0] cid_r, cid_nxt;
  logic [31:0] clen_r, clen_nxt;
  logic [32:0] skip_r, skip_nxt;
  logic [32:0] lcons_r, lcons_nxt;
  logic [31:0] sid_r, sid_nxt;
  logic [31:0] slen_r, slen_nxt;
  logic [6:0]  tpos_r, tpos_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] off_r, off_nxt;
  logic [31:0] samp_r, samp_nxt;
  logic        eofp_r, eofp_nxt;

  // Pending text request.
  logic        tv_r, tv_nxt;
  logic [1:0]  tkind_r, tkind_nxt;
  logic [7:0]  tbyte_r, tbyte_nxt;
  logic [6:0]  tidx_r, tidx_nxt;
  logic        tlast_r, tlast_nxt;

  // Pending summary request.
  logic        sv_r, sv_nxt;
  logic [31:0] s_rate_r, s_rate_nxt;
  logic [15:0] s_chan_r, s_chan_nxt;
  logic [15:0] s_bits_r, s_bits_nxt;
  logic [31:0] s_off_r, s_off_nxt;
  logic [31:0] s_samp_r, s_samp_nxt;

  wrhp_pkg::div_req_t dreq;
  wrhp_pkg::div_rsp_t drsp;

  logic        acc;
  logic [28:0] frame_bytes;

  assign in_tready = !tv_r && !sv_r && !eofp_r && !drsp.busy && !drsp.done;
  assign acc       = in_tvalid && in_tready;

  // Bytes per frame: channels times whole bytes per sample.
  assign frame_bytes = chan_r * bits_r[15:3];

  always_comb begin
    logic [31:0] sh;
    logic [3:0]  cnt;
    logic [3:0]  fidx;
    logic [31:0] lim;
    logic        last;
    logic [33:0] lsum;
    logic [32:0] n;
    logic        clr;

    sh   = {in_tdata, fshift_r[31:8]};
    cnt  = {1'b0, fcnt_r} + 4'd1;
    fidx = 4'(5'd16 - {1'b0, skip_r[3:0]});
    lim  = (slen_r < 32'(MAX_TEXT)) ? slen_r : 32'(MAX_TEXT);
    last = ({25'd0, tpos_r} + 32'd1) >= lim;
    lsum = {1'b0, lcons_r} + 34'd8 + {2'b0, slen_r} + {33'd0, slen_r[0]};
    n    = '0;
    clr  = 1'b0;

    phase_nxt = phase_r;   bpos_nxt = bpos_r;   fshift_nxt = fshift_r;
    fcnt_nxt  = fcnt_r;    cid_nxt  = cid_r;    clen_nxt   = clen_r;
    skip_nxt  = skip_r;    lcons_nxt = lcons_r; sid_nxt    = sid_r;
    slen_nxt  = slen_r;    tpos_nxt = tpos_r;   rate_nxt   = rate_r;
    chan_nxt  = chan_r;    bits_nxt = bits_r;   off_nxt    = off_r;
    samp_nxt  = samp_r;    eofp_nxt = eofp_r;
    tv_nxt = tv_r; tkind_nxt = tkind_r; tbyte_nxt = tbyte_r;
    tidx_nxt = tidx_r; tlast_nxt = tlast_r;
    sv_nxt = sv_r; s_rate_nxt = s_rate_r; s_chan_nxt = s_chan_r;
    s_bits_nxt = s_bits_r; s_off_nxt = s_off_r; s_samp_nxt = s_samp_r;

    dreq.start    = 1'b0;
    dreq.dividend = sh;
    dreq.divisor  = {3'd0, frame_bytes};

    // The text request always goes out ahead of the summary.
    if (out_tvalid && out_tready) begin
      if (tv_r) begin
        tv_nxt = 1'b0;
      end else begin
        sv_nxt = 1'b0;
      end
    end

    if (acc) begin
      bpos_nxt = bpos_r + 32'd1;
      unique case (phase_r)
        PH_SKIP: begin
          if (skip_r <= 33'd1) begin
            phase_nxt = PH_CHDR;
          end else begin
            skip_nxt = skip_r - 33'd1;
          end
        end
        PH_CHDR, PH_SHDR: begin
          fshift_nxt = sh;
          if (cnt == 4'd4) begin
            if (phase_r == PH_CHDR) begin
              cid_nxt = sh;
            end else begin
              sid_nxt = sh;
            end
          end
          if (cnt >= 4'd8) begin
            cnt = '0;
            if (phase_r == PH_CHDR) begin
              clen_nxt = sh;
              if (cid_r == wrhp_pkg::ID_FMT) begin
                skip_nxt  = wrhp_pkg::FMT_BYTES;
                phase_nxt = PH_FMT;
              end else if (cid_r == wrhp_pkg::ID_LIST) begin
                phase_nxt = PH_LTYPE;
              end else begin
                if (cid_r == wrhp_pkg::ID_DATA) begin
                  off_nxt = bpos_r + 32'd1;
                  if (frame_bytes != '0) begin
                    dreq.start = 1'b1;
                  end else begin
                    samp_nxt = '0;
                  end
                end
                n = {1'b0, sh} + {32'd0, sh[0]};
                if (n == '0) begin
                  phase_nxt = PH_CHDR;
                end else begin
                  skip_nxt  = n;
                  phase_nxt = PH_SKIP;
                end
              end
            end else begin
              slen_nxt  = sh;
              lsum      = {1'b0, lcons_r} + 34'd8 + {2'b0, sh} + {33'd0, sh[0]};
              lcons_nxt = (lsum > {1'b0, wrhp_pkg::SAT33}) ? wrhp_pkg::SAT33 : lsum[32:0];
              tpos_nxt  = '0;
              if ((sid_r == wrhp_pkg::ID_INAM || sid_r == wrhp_pkg::ID_IART) && sh != '0) begin
                phase_nxt = PH_TEXT;
              end else begin
                n = {1'b0, sh} + {32'd0, sh[0]};
                if (n == '0) begin
                  phase_nxt = (lcons_nxt < {1'b0, clen_r}) ? PH_SHDR : PH_CHDR;
                end else begin
                  skip_nxt  = n;
                  phase_nxt = PH_SSKIP;
                end
              end
            end
          end
          fcnt_nxt = cnt[2:0];
        end
        PH_FMT: begin
          fshift_nxt = sh;
          if (fidx == 4'd3) begin
            chan_nxt = sh[31:16];
          end else if (fidx == 4'd7) begin
            rate_nxt = sh;
          end else if (fidx == 4'd15) begin
            bits_nxt = sh[31:16];
          end
          if (skip_r <= 33'd1) begin
            n = (clen_r >= 32'd16) ?
                ({1'b0, clen_r} - wrhp_pkg::FMT_BYTES + {32'd0, clen_r[0]}) : 33'd0;
            if (n == '0) begin
              phase_nxt = PH_CHDR;
            end else begin
              skip_nxt  = n;
              phase_nxt = PH_SKIP;
            end
          end else begin
            skip_nxt = skip_r - 33'd1;
          end
        end
        PH_LTYPE: begin
          fshift_nxt = sh;
          if (cnt >= 4'd4) begin
            cnt = '0;
            if (sh == wrhp_pkg::ID_INFO) begin
              lcons_nxt = 33'd4;
              phase_nxt = (33'd4 < {1'b0, clen_r}) ? PH_SHDR : PH_CHDR;
            end else begin
              n = (clen_r >= 32'd4) ?
                  ({1'b0, clen_r} - 33'd4 + {32'd0, clen_r[0]}) : 33'd0;
              if (n == '0) begin
                phase_nxt = PH_CHDR;
              end else begin
                skip_nxt  = n;
                phase_nxt = PH_SKIP;
              end
            end
          end
          fcnt_nxt = cnt[2:0];
        end
        PH_TEXT: begin
          tv_nxt    = 1'b1;
          tkind_nxt = (sid_r == wrhp_pkg::ID_INAM) ? wrhp_pkg::KIND_TITLE
                                                   : wrhp_pkg::KIND_ARTIST;
          tbyte_nxt = in_tdata;
          tidx_nxt  = tpos_r;
          tlast_nxt = last;
          tpos_nxt  = tpos_r + 7'd1;
          if (last) begin
            n = {1'b0, slen_r - lim} + {32'd0, slen_r[0]};
            if (n == '0) begin
              phase_nxt = (lcons_r < {1'b0, clen_r}) ? PH_SHDR : PH_CHDR;
            end else begin
              skip_nxt  = n;
              phase_nxt = PH_SSKIP;
            end
          end
        end
        PH_SSKIP: begin
          if (skip_r <= 33'd1) begin
            phase_nxt = (lcons_r < {1'b0, clen_r}) ? PH_SHDR : PH_CHDR;
          end else begin
            skip_nxt = skip_r - 33'd1;
          end
        end
        default: begin
          phase_nxt = PH_CHDR;
        end
      endcase

      // End of file: the summary waits for a running division to finish.
      if (in_tlast) begin
        if (dreq.start) begin
          eofp_nxt = 1'b1;
        end else begin
          clr = 1'b1;
        end
      end
    end

    if (drsp.done) begin
      samp_nxt = drsp.quotient;
      if (eofp_r) begin
        clr = 1'b1;
      end
    end

    if (clr) begin
      sv_nxt     = 1'b1;
      s_rate_nxt = rate_nxt;
      s_chan_nxt = chan_nxt;
      s_bits_nxt = bits_nxt;
      s_off_nxt  = off_nxt;
      s_samp_nxt = samp_nxt;
      phase_nxt  = PH_SKIP;   bpos_nxt = '0;  fshift_nxt = '0;  fcnt_nxt = '0;
      cid_nxt    = '0;        clen_nxt = '0;  skip_nxt = wrhp_pkg::HEADER_SKIP;
      lcons_nxt  = '0;        sid_nxt  = '0;  slen_nxt = '0;    tpos_nxt = '0;
      rate_nxt   = '0;        chan_nxt = '0;  bits_nxt = '0;    off_nxt  = '0;
      samp_nxt   = '0;        eofp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;   bpos_r <= '0;  fshift_r <= '0;  fcnt_r <= '0;
      cid_r   <= '0;        clen_r <= '0;  skip_r <= wrhp_pkg::HEADER_SKIP;
      lcons_r <= '0;        sid_r  <= '0;  slen_r <= '0;    tpos_r <= '0;
      rate_r  <= '0;        chan_r <= '0;  bits_r <= '0;    off_r  <= '0;
      samp_r  <= '0;        eofp_r <= 1'b0;
      tv_r    <= 1'b0;      sv_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt; bpos_r <= bpos_nxt; fshift_r <= fshift_nxt;
      fcnt_r  <= fcnt_nxt;  cid_r  <= cid_nxt;  clen_r   <= clen_nxt;
      skip_r  <= skip_nxt;  lcons_r <= lcons_nxt; sid_r  <= sid_nxt;
      slen_r  <= slen_nxt;  tpos_r <= tpos_nxt; rate_r   <= rate_nxt;
      chan_r  <= chan_nxt;  bits_r <= bits_nxt; off_r    <= off_nxt;
      samp_r  <= samp_nxt;  eofp_r <= eofp_nxt;
      tv_r    <= tv_nxt;    sv_r   <= sv_nxt;
    end
    tkind_r  <= tkind_nxt;  tbyte_r  <= tbyte_nxt; tidx_r <= tidx_nxt;
    tlast_r  <= tlast_nxt;
    s_rate_r <= s_rate_nxt; s_chan_r <= s_chan_nxt; s_bits_r <= s_bits_nxt;
    s_off_r  <= s_off_nxt;  s_samp_r <= s_samp_nxt;
  end

  wrhp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign out_tvalid = tv_r || sv_r;
  assign out_tdata  = tv_r ? {129'd0, tidx_r, tbyte_r}
                           : {1'b0, s_samp_r, s_off_r, s_bits_r, s_chan_r, s_rate_r, 15'd0};
  assign out_tuser  = tv_r ? tkind_r : wrhp_pkg::KIND_SUM;
  assign out_tlast  = tv_r && tlast_r;

  // No byte may be taken while the divider is running.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.busy |-> !in_tready) else $error("byte accepted during division");

  // A pending end of file is only ever waiting on the divider.
  a_eof_wait: assert property (@(posedge clk) disable iff (!rst_n)
    eofp_r |-> (drsp.busy || drsp.done)) else $error("summary stuck");

  // Summaries never carry the text end mark.
  a_sum_nolast: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == wrhp_pkg::KIND_SUM) |-> !out_tlast)
    else $error("summary with tlast");

endmodule

@@ rtl/wrhp_div.sv @@
// Restoring divider, one quotient bit per cycle. The divisor must be nonzero.
module wrhp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  wrhp_pkg::div_req_t req,
  output wrhp_pkg::div_rsp_t rsp
);

  localparam int CW = $clog2(wrhp_pkg::QW);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [wrhp_pkg::QW-1:0] rem_r, rem_nxt;
  logic [wrhp_pkg::QW-1:0] quo_r, quo_nxt;
  logic [wrhp_pkg::QW-1:0] dvs_r, dvs_nxt;
  logic [wrhp_pkg::QW:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[wrhp_pkg::QW-1]} - {1'b0, dvs_r};
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial[wrhp_pkg::QW]) begin
        rem_nxt = {rem_r[wrhp_pkg::QW-2:0], quo_r[wrhp_pkg::QW-1]};
      end else begin
        rem_nxt = trial[wrhp_pkg::QW-1:0];
      end
      quo_nxt = {quo_r[wrhp_pkg::QW-2:0], ~trial[wrhp_pkg::QW]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(wrhp_pkg::QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ sim/wav_riff_header_parser_unit_tb.sv @@
module wav_riff_header_parser_unit_tb;

  // Parser phases of the predictor; they mirror the walk through the file.
  typedef enum logic [3:0] {
    PH_SKIP, PH_CHDR, PH_FMT, PH_LTYPE, PH_SHDR, PH_TEXT, PH_SSKIP
  } walk_phase_t;

  // One predicted output request, fields as they appear on the output bus.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  text_byte;
    logic [6:0]  text_index;
    logic        text_last;
    logic [31:0] fmt_rate;
    logic [15:0] channels;
    logic [15:0] sample_bits;
    logic [31:0] data_offset;
    logic [31:0] frame_count;
  } wav_result_t;

  localparam int TEXT_MAX = 127;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  wav_riff_header_parser_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  // Pending file bytes: bit 8 carries the end-of-file flag.
  logic [8:0]  byte_queue[$];
  wav_result_t expected_results[$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          in_taken = 1'b0;

  // Predictor state.
  walk_phase_t w_phase;
  logic [31:0] w_pos, w_shift, w_cid, w_clen, w_sid, w_slen;
  logic [2:0]  w_cnt;
  logic [32:0] w_skip, w_consumed;
  logic [6:0]  w_tpos;
  logic [31:0] w_rate, w_off, w_samples;
  logic [15:0] w_chan, w_bits;

  function automatic wav_result_t text_result(logic [1:0] k, logic [7:0] b,
                                              logic [6:0] idx, logic lst);
    wav_result_t r;
    r = '0;
    r.kind = k; r.text_byte = b; r.text_index = idx; r.text_last = lst;
    return r;
  endfunction

  task automatic walk_reset();
    w_phase = PH_SKIP; w_pos = 0; w_shift = 0; w_cnt = 0; w_cid = 0; w_clen = 0;
    w_skip = wrhp_pkg::HEADER_SKIP; w_consumed = 0; w_sid = 0; w_slen = 0; w_tpos = 0;
    w_rate = 0; w_chan = 0; w_bits = 0; w_off = 0; w_samples = 0;
  endtask

  task automatic chunk_skip(logic [32:0] n);
    if (n == 0) w_phase = PH_CHDR;
    else begin
      w_skip = n; w_phase = PH_SKIP;
    end
  endtask

  task automatic after_sub();
    w_phase = ({1'b0, w_clen} > w_consumed) ? PH_SHDR : PH_CHDR;
  endtask

  task automatic sub_skip(logic [32:0] n);
    if (n == 0) after_sub();
    else begin
      w_skip = n; w_phase = PH_SSKIP;
    end
  endtask

  // Advances the predictor by one file byte and queues what it produces.
  task automatic walk_byte(logic [7:0] b, logic eof);
    logic [3:0]  cnt;
    logic [31:0] frame, lim;
    logic [33:0] sum;
    logic [3:0]  idx;
    logic        lst;
    wav_result_t r;
    w_pos = w_pos + 32'd1;
    unique case (w_phase)
      PH_SKIP: begin
        if (w_skip <= 1) w_phase = PH_CHDR;
        else w_skip = w_skip - 33'd1;
      end
      PH_CHDR, PH_SHDR: begin
        w_shift = {b, w_shift[31:8]};
        cnt = {1'b0, w_cnt} + 4'd1;
        if (cnt == 4) begin
          if (w_phase == PH_CHDR) w_cid = w_shift;
          else w_sid = w_shift;
        end
        if (cnt >= 8) begin
          cnt = '0;
          if (w_phase == PH_CHDR) begin
            w_clen = w_shift;
            if (w_cid == wrhp_pkg::ID_FMT) begin
              w_skip = wrhp_pkg::FMT_BYTES; w_phase = PH_FMT;
            end else if (w_cid == wrhp_pkg::ID_LIST) begin
              w_phase = PH_LTYPE;
            end else begin
              if (w_cid == wrhp_pkg::ID_DATA) begin
                frame = w_chan * (w_bits >> 3);
                w_off = w_pos;
                w_samples = (frame != 0) ? w_clen / frame : 0;
              end
              chunk_skip({1'b0, w_clen} + w_clen[0]);
            end
          end else begin
            w_slen = w_shift;
            sum = w_consumed + 34'd8 + w_slen + w_slen[0];
            w_consumed = (sum > wrhp_pkg::SAT33) ? wrhp_pkg::SAT33 : sum[32:0];
            w_tpos = 0;
            if ((w_sid == wrhp_pkg::ID_INAM || w_sid == wrhp_pkg::ID_IART) && w_slen != 0)
              w_phase = PH_TEXT;
            else sub_skip({1'b0, w_slen} + w_slen[0]);
          end
        end
        w_cnt = cnt[2:0];
      end
      PH_FMT: begin
        idx = 4'(wrhp_pkg::FMT_BYTES - w_skip);
        w_shift = {b, w_shift[31:8]};
        if (idx == 3) w_chan = w_shift[31:16];
        else if (idx == 7) w_rate = w_shift;
        else if (idx == 15) w_bits = w_shift[31:16];
        if (w_skip <= 1)
          chunk_skip(w_clen >= 16 ? {1'b0, w_clen} - 33'd16 + w_clen[0] : 33'd0);
        else w_skip = w_skip - 33'd1;
      end
      PH_LTYPE: begin
        w_shift = {b, w_shift[31:8]};
        cnt = {1'b0, w_cnt} + 4'd1;
        if (cnt >= 4) begin
          cnt = '0;
          if (w_shift == wrhp_pkg::ID_INFO) begin
            w_consumed = 33'd4; after_sub();
          end else begin
            chunk_skip(w_clen >= 4 ? {1'b0, w_clen} - 33'd4 + w_clen[0] : 33'd0);
          end
        end
        w_cnt = cnt[2:0];
      end
      PH_TEXT: begin
        lim = (w_slen < TEXT_MAX) ? w_slen : TEXT_MAX;
        lst = ({25'd0, w_tpos} + 32'd1 >= lim);
        expected_results.push_back(text_result(
          (w_sid == wrhp_pkg::ID_INAM) ? wrhp_pkg::KIND_TITLE : wrhp_pkg::KIND_ARTIST,
          b, w_tpos, lst));
        w_tpos = w_tpos + 7'd1;
        if (lst) sub_skip({1'b0, w_slen - lim} + w_slen[0]);
      end
      PH_SSKIP: begin
        if (w_skip <= 1) after_sub();
        else w_skip = w_skip - 33'd1;
      end
      default: w_phase = PH_CHDR;
    endcase
    if (eof) begin
      r = '0;
      r.kind = wrhp_pkg::KIND_SUM; r.fmt_rate = w_rate; r.channels = w_chan;
      r.sample_bits = w_bits; r.data_offset = w_off; r.frame_count = w_samples;
      expected_results.push_back(r);
      walk_reset();
    end
  endtask

  // File building helpers.
  task automatic put_byte(logic [7:0] b);
    byte_queue.push_back({1'b0, b});
  endtask

  task automatic put_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) put_byte(w[8*i +: 8]);
  endtask

  task automatic put_short(logic [15:0] h);
    put_byte(h[7:0]); put_byte(h[15:8]);
  endtask

  task automatic put_random(int n);
    for (int i = 0; i < n; i++) put_byte(8'($urandom));
  endtask

  task automatic end_file();
    if (byte_queue.size() == 0) put_byte(8'($urandom));
    byte_queue[$][8] = 1'b1;
  endtask

  task automatic put_header();
    put_word(32'h46464952); put_word($urandom); put_word(32'h45564157);
  endtask

  task automatic put_fmt(int flen, logic [15:0] ch, logic [31:0] rate,
                         logic [15:0] bits);
    put_word(wrhp_pkg::ID_FMT); put_word(flen);
    put_short(16'($urandom)); put_short(ch); put_word(rate); put_word($urandom);
    put_short(16'($urandom)); put_short(bits);
    if (flen > 16) put_random(flen - 16 + (flen & 1));
  endtask

  task automatic put_text_sub(logic [31:0] id, int tlen);
    put_word(id); put_word(tlen); put_random(tlen + (tlen & 1));
  endtask

  // A random file: random content, a random chunk order, now and then a malformed chunk length.
  task automatic put_random_file();
    int nch, sel, nsub, tl, llen, dlen;
    logic [31:0] ids[$];
    put_header();
    nch = $urandom_range(1, 4);
    for (int c = 0; c < nch; c++) begin
      sel = $urandom_range(0, 5);
      unique case (sel)
        0, 1: put_fmt(($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : 16,
                      16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8)),
                      $urandom,
                      16'($urandom_range(0, 3) == 0 ? $urandom : 8 * $urandom_range(0, 4)));
        2, 3: begin
          nsub = $urandom_range(0, 3);
          ids.delete();
          llen = 4;
          for (int s = 0; s < nsub; s++) begin
            tl = ($urandom_range(0, 15) == 0) ? $urandom_range(120, 140)
                                               : $urandom_range(0, 9);
            ids.push_back(tl);
            llen += 8 + tl + (tl & 1);
          end
          put_word(wrhp_pkg::ID_LIST);
          put_word(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : llen);
          put_word(($urandom_range(0, 7) == 0) ? 32'($urandom) : wrhp_pkg::ID_INFO);
          foreach (ids[s]) begin
            sel = $urandom_range(0, 4);
            put_text_sub(sel < 2 ? wrhp_pkg::ID_INAM
                                 : (sel < 4 ? wrhp_pkg::ID_IART : 32'($urandom)),
                         ids[s]);
          end
        end
        4: begin
          dlen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 12);
          put_word(wrhp_pkg::ID_DATA); put_word(dlen); put_random(dlen + (dlen & 1));
        end
        default: begin
          dlen = $urandom_range(0, 7);
          put_word($urandom); put_word(dlen); put_random(dlen + (dlen & 1));
        end
      endcase
    end
    // Now and then append up to three stray bytes and/or cut one to four bytes off the end.
    if ($urandom_range(0, 5) == 0) put_random($urandom_range(0, 3));
    if ($urandom_range(0, 5) == 0 && byte_queue.size() > 4)
      repeat ($urandom_range(1, 4)) void'(byte_queue.pop_back());
    end_file();
  endtask

  // Driver: at the falling edge, offers the next byte once the current one was
  // taken at the rising edge before, idling at random; also draws out_tready.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          {in_tlast, in_tdata} <= byte_queue.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: feeds every accepted byte to the predictor and compares every
  // accepted output request with the oldest prediction.
  always @(posedge clk) begin
    wav_result_t got, want;
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) begin
      walk_byte(in_tdata, in_tlast);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser; got.text_last = out_tlast;
      got.text_byte = out_tdata[7:0]; got.text_index = out_tdata[14:8];
      got.fmt_rate = out_tdata[46:15]; got.channels = out_tdata[62:47];
      got.sample_bits = out_tdata[78:63]; got.data_offset = out_tdata[110:79];
      got.frame_count = out_tdata[142:111];
      if (expected_results.size() == 0) begin
        $error("unexpected output request kind=%0d", got.kind);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.kind != want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, got.kind); error_count++;
        end
        if (got.text_byte != want.text_byte) begin
          $error("text_byte: expected %0h, got %0h", want.text_byte, got.text_byte);
          error_count++;
        end
        if (got.text_index != want.text_index) begin
          $error("text_index: expected %0d, got %0d", want.text_index, got.text_index);
          error_count++;
        end
        if (got.text_last != want.text_last) begin
          $error("text_last: expected %0d, got %0d", want.text_last, got.text_last);
          error_count++;
        end
        if (got.fmt_rate != want.fmt_rate) begin
          $error("fmt_rate: expected %0h, got %0h", want.fmt_rate, got.fmt_rate);
          error_count++;
        end
        if (got.channels != want.channels) begin
          $error("channels: expected %0h, got %0h", want.channels, got.channels);
          error_count++;
        end
        if (got.sample_bits != want.sample_bits) begin
          $error("sample_bits: expected %0h, got %0h", want.sample_bits, got.sample_bits);
          error_count++;
        end
        if (got.data_offset != want.data_offset) begin
          $error("data_offset: expected %0h, got %0h", want.data_offset, got.data_offset);
          error_count++;
        end
        if (got.frame_count != want.frame_count) begin
          $error("frame_count: expected %0h, got %0h", want.frame_count,
                 got.frame_count);
          error_count++;
        end
      end
    end
  end

  // Stimulus: a directed set of files, then random files over four phases of input idling and output stalling.
  initial begin
    int target;
    walk_reset();
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Extremes of the byte value, a one-byte file, and a data chunk before fmt
    // so the frame size is zero.
    put_byte(8'h00); put_byte(8'hFF); end_file();
    put_byte(8'hA5); end_file();
    put_header(); put_word(wrhp_pkg::ID_DATA); put_word(2); put_short(16'hFFFF); end_file();
    // Short fmt, then a data chunk with a real divide, a short LIST that is not
    // INFO, and an INFO list with an empty title and a 130-byte artist string.
    put_header(); put_fmt(4, 16'd2, 32'hFFFFFFFF, 16'd16);
    put_word(wrhp_pkg::ID_DATA); put_word(9); put_random(10);
    put_word(wrhp_pkg::ID_LIST); put_word(2); put_word(32'h12345678);
    put_word(wrhp_pkg::ID_LIST); put_word(4 + 8 + 8 + 130); put_word(wrhp_pkg::ID_INFO);
    put_text_sub(wrhp_pkg::ID_INAM, 0); put_text_sub(wrhp_pkg::ID_IART, 130);
    put_fmt(16, 16'hFFFF, 32'd0, 16'hFFFF);
    end_file();
    // File cut off inside a title string.
    put_header(); put_word(wrhp_pkg::ID_LIST); put_word(20); put_word(wrhp_pkg::ID_INFO);
    put_word(wrhp_pkg::ID_INAM); put_word(8); put_random(3); end_file();

    for (int ph = 0; ph < 4; ph++) begin
      unique case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      target = 160;
      while (target > 0) begin
        int before_n;
        before_n = byte_queue.size();
        if ($urandom_range(0, 9) == 0) begin
          put_random($urandom_range(1, 30)); end_file();
        end else begin
          put_random_file();
        end
        target -= byte_queue.size() - before_n;
      end
      wait (byte_queue.size() == 0);
    end
    // Drain: input idle, then output has nothing pending.
    wait (byte_queue.size() == 0 && !in_tvalid);
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
